// ===== src/pfc_pkg.sv =====
// Shared types and constants for the PRBS frame checker.
`default_nettype none
package pfc_pkg;

  localparam int DATA_BITS      = 64;
  localparam int NARROW_BITS    = 32;
  localparam int SEQ_BITS       = 32;
  localparam int VB_BITS        = 4;
  localparam int IN_USER_BITS   = VB_BITS + 1;
  localparam int STATUS_BITS    = 3;
  localparam int OUT_FIELD_BITS = 32;
  localparam int OUT_DATA_BITS  = 136;
  localparam int CFG_INDEX_BITS = 2;

  localparam logic [DATA_BITS-1:0] TAP_MASK_RESET = 64'h0000_0000_8000_0046;
  localparam logic [VB_BITS-1:0]   BYTES_NARROW   = 4'd4;
  localparam logic [VB_BITS-1:0]   BYTES_WIDE     = 4'd8;
  localparam logic [SEQ_BITS:0]    MIN_WORDS      = 33'd3;

  typedef enum logic [STATUS_BITS-1:0] {
    ST_OK        = 3'd0,
    ST_FRAME_ERR = 3'd1,
    ST_SIZE      = 3'd2,
    ST_HEADER    = 3'd3,
    ST_PAYLOAD   = 3'd4
  } status_t;

  localparam logic [CFG_INDEX_BITS-1:0] CFG_WIDE_WORDS    = 2'd0;
  localparam logic [CFG_INDEX_BITS-1:0] CFG_TAP_MASK      = 2'd1;
  localparam logic [CFG_INDEX_BITS-1:0] CFG_CHECK_PAYLOAD = 2'd2;

endpackage
`default_nettype wire

// ===== src/pfc_lfsr.sv =====
// One-step LFSR advance with tap mask and word-width select.
`default_nettype none
module pfc_lfsr #(
  parameter int W = 64
) (
  input  wire logic [W-1:0] value,
  input  wire logic [W-1:0] taps,
  input  wire logic         wide,
  output logic      [W-1:0] next_value
);
  import pfc_pkg::*;

  logic [W-1:0] width_mask;
  logic         feedback;

  always_comb begin
    width_mask = wide ? {W{1'b1}} : W'({NARROW_BITS{1'b1}});
    feedback   = ^(value & taps & width_mask);
    next_value = {value[W-2:0], feedback} & width_mask;
  end

endmodule
`default_nettype wire

// ===== src/prbs_frame_checker.sv =====
// Top level of the PRBS frame checker: input register, check logic, result register.
//
//  channel | direction | handshake           | payload
//  in_     | slave     | in_tvalid/in_tready | in_tdata, in_tlast, in_tuser
//  out_    | master    | out_tvalid/out_tready | out_tdata
//  cfg_    | slave     | cfg_valid/cfg_ready | cfg_index, cfg_data
//
// One word is accepted per cycle while no held result stalls a last word; a word's checks run from the input register.
// A result is written to the result register when the last word of its frame leaves the input register.
// The single LFSR step and compare sit between the two registers.
// Reset clears all frame state and counters and loads the register defaults.
// A held result stalls only a further last word; other words keep flowing.
`default_nettype none
module prbs_frame_checker #(
  parameter int MAX_WORD_BITS = 64,
  parameter int COUNTER_BITS  = 32
) (
  input  wire logic                                  clk,
  input  wire logic                                  rst_n,
  input  wire logic                                  in_tvalid,
  output logic                                       in_tready,
  input  wire logic [pfc_pkg::DATA_BITS-1:0]         in_tdata,   // [63:0] data_word
  input  wire logic                                  in_tlast,
  input  wire logic [pfc_pkg::IN_USER_BITS-1:0]      in_tuser,   // [3:0] valid_bytes, [4] frame_error
  output logic                                       out_tvalid,
  input  wire logic                                  out_tready,
  // [2:0] status, [34:3] error_count, [66:35] frame_count, [98:67] byte_count,
  // [130:99] next_sequence, [135:131] zero
  output logic      [pfc_pkg::OUT_DATA_BITS-1:0]     out_tdata,
  input  wire logic                                  cfg_valid,
  output logic                                       cfg_ready,
  input  wire logic [pfc_pkg::CFG_INDEX_BITS-1:0]    cfg_index,
  input  wire logic [pfc_pkg::DATA_BITS-1:0]         cfg_data
);
  import pfc_pkg::*;

  localparam bit WIDE_OK = (MAX_WORD_BITS >= 64);
  localparam int LW      = WIDE_OK ? 64 : 32;

  // configuration
  logic          wide_r;
  logic [LW-1:0] tap_mask_r;
  logic          check_r;
  logic          wide_eff;

  // input register
  logic                 in_v_r;
  logic [DATA_BITS-1:0] in_data_r;
  logic                 in_last_r;
  logic [VB_BITS-1:0]   in_vb_r;
  logic                 in_fe_r;

  // frame state
  logic [SEQ_BITS-1:0]     exp_seq_r,   exp_seq_nxt;
  logic [LW-1:0]           lfsr_r,      lfsr_nxt;
  logic [SEQ_BITS-1:0]     wpos_r,      wpos_nxt;
  logic [SEQ_BITS-1:0]     held_seq_r,  held_seq_nxt;
  logic [SEQ_BITS-1:0]     held_size_r, held_size_nxt;
  logic                    pbad_r,      pbad_nxt;
  logic                    tbad_r,      tbad_nxt;
  logic [COUNTER_BITS-1:0] rej_r,       rej_nxt;
  logic [COUNTER_BITS-1:0] good_r,      good_nxt;
  logic [COUNTER_BITS-1:0] bytes_r,     bytes_nxt;

  // result register
  logic                     out_v_r;
  logic [OUT_DATA_BITS-1:0] out_data_r, out_data_nxt;

  logic          proc;
  logic          in_fire;
  logic [LW-1:0] word;
  logic [LW-1:0] lfsr_step;
  logic [SEQ_BITS:0] words;
  logic [VB_BITS-1:0] bpw;
  logic [63:0]   bytes_add;
  status_t       status;

  assign cfg_ready = 1'b1;
  assign wide_eff  = wide_r & WIDE_OK;

  assign proc      = in_v_r & (~in_last_r | ~out_v_r | out_tready);
  assign in_tready = ~in_v_r | proc;
  assign in_fire   = in_tvalid & in_tready;

  assign out_tvalid = out_v_r;
  assign out_tdata  = out_data_r;

  pfc_lfsr #(.W(LW)) u_lfsr (
    .value      (lfsr_r),
    .taps       (tap_mask_r),
    .wide       (wide_eff),
    .next_value (lfsr_step)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wide_r     <= 1'b0;
      tap_mask_r <= TAP_MASK_RESET[LW-1:0];
      check_r    <= 1'b1;
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_WIDE_WORDS:    wide_r     <= cfg_data[0];
        CFG_TAP_MASK:      tap_mask_r <= cfg_data[LW-1:0];
        CFG_CHECK_PAYLOAD: check_r    <= cfg_data[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r <= 1'b0;
    end else if (in_fire) begin
      in_v_r <= 1'b1;
    end else if (proc) begin
      in_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      in_data_r <= in_tdata;
      in_last_r <= in_tlast;
      in_vb_r   <= in_tuser[VB_BITS-1:0];
      in_fe_r   <= in_tuser[VB_BITS];
    end
  end

  always_comb begin
    word = wide_eff ? in_data_r[LW-1:0] : LW'(in_data_r[NARROW_BITS-1:0]);
    bpw  = wide_eff ? BYTES_WIDE : BYTES_NARROW;

    exp_seq_nxt   = exp_seq_r;
    lfsr_nxt      = lfsr_r;
    held_seq_nxt  = held_seq_r;
    held_size_nxt = held_size_r;
    pbad_nxt      = pbad_r;
    tbad_nxt      = tbad_r | in_fe_r;
    rej_nxt       = rej_r;
    good_nxt      = good_r;
    bytes_nxt     = bytes_r;
    status        = ST_OK;

    if (wpos_r == '0) begin
      held_seq_nxt = word[SEQ_BITS-1:0];
      lfsr_nxt     = word;
    end else if (wpos_r == SEQ_BITS'(1)) begin
      held_size_nxt = word[SEQ_BITS-1:0];
    end else if (check_r) begin
      lfsr_nxt = lfsr_step;
      if (lfsr_step != word) begin
        pbad_nxt = 1'b1;
      end
    end

    words     = {1'b0, wpos_r} + (SEQ_BITS+1)'(1);
    wpos_nxt  = (&wpos_r) ? wpos_r : wpos_r + SEQ_BITS'(1);
    bytes_add = wide_eff ? (64'(words) << 3) : (64'(words) << 2);

    if (in_last_r) begin
      if (tbad_nxt) begin
        status = ST_FRAME_ERR;
      end else if (in_vb_r < bpw || words < MIN_WORDS) begin
        status = ST_SIZE;
      end else begin
        exp_seq_nxt = held_seq_nxt + SEQ_BITS'(1);
        if ({1'b0, held_size_nxt} + (SEQ_BITS+1)'(1) != words ||
            (held_seq_nxt != '0 && exp_seq_r != '0 && held_seq_nxt != exp_seq_r)) begin
          status = ST_HEADER;
        end else if (pbad_nxt) begin
          status = ST_PAYLOAD;
        end else begin
          status = ST_OK;
        end
      end

      if (status == ST_OK) begin
        good_nxt  = good_r + COUNTER_BITS'(1);
        bytes_nxt = bytes_r + bytes_add[COUNTER_BITS-1:0];
      end else begin
        rej_nxt = rej_r + COUNTER_BITS'(1);
      end

      wpos_nxt = '0;
      pbad_nxt = 1'b0;
      tbad_nxt = 1'b0;
    end

    out_data_nxt = {5'b0,
                    exp_seq_nxt,
                    OUT_FIELD_BITS'(bytes_nxt),
                    OUT_FIELD_BITS'(good_nxt),
                    OUT_FIELD_BITS'(rej_nxt),
                    status};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      exp_seq_r   <= '0;
      lfsr_r      <= '0;
      wpos_r      <= '0;
      held_seq_r  <= '0;
      held_size_r <= '0;
      pbad_r      <= 1'b0;
      tbad_r      <= 1'b0;
      rej_r       <= '0;
      good_r      <= '0;
      bytes_r     <= '0;
    end else if (proc) begin
      exp_seq_r   <= exp_seq_nxt;
      lfsr_r      <= lfsr_nxt;
      wpos_r      <= wpos_nxt;
      held_seq_r  <= held_seq_nxt;
      held_size_r <= held_size_nxt;
      pbad_r      <= pbad_nxt;
      tbad_r      <= tbad_nxt;
      rej_r       <= rej_nxt;
      good_r      <= good_nxt;
      bytes_r     <= bytes_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (proc && in_last_r) begin
      out_v_r <= 1'b1;
    end else if (out_tready) begin
      out_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (proc && in_last_r) begin
      out_data_r <= out_data_nxt;
    end
  end

endmodule
`default_nettype wire

// ===== src/pfc_checker.sv =====
// Port-level assertions for the PRBS frame checker, bound to the top level.
`default_nettype none
module pfc_checker (
  input wire logic                                clk,
  input wire logic                                rst_n,
  input wire logic                                out_tvalid,
  input wire logic                                out_tready,
  input wire logic [pfc_pkg::OUT_DATA_BITS-1:0]   out_tdata
);
  import pfc_pkg::*;

  logic [15:0] prev_err_r;
  logic [15:0] prev_good_r;
  logic        out_fire;
  logic [15:0] err16;
  logic [15:0] good16;
  logic        is_ok;

  assign out_fire = out_tvalid & out_tready;
  assign err16    = out_tdata[18:3];
  assign good16   = out_tdata[50:35];
  assign is_ok    = (out_tdata[2:0] == ST_OK);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_err_r  <= '0;
      prev_good_r <= '0;
    end else if (out_fire) begin
      prev_err_r  <= err16;
      prev_good_r <= good16;
    end
  end

  a_hold_result: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result changed while stalled");

  a_status_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[2:0] == ST_OK || out_tdata[2:0] == ST_FRAME_ERR ||
                   out_tdata[2:0] == ST_SIZE || out_tdata[2:0] == ST_HEADER ||
                   out_tdata[2:0] == ST_PAYLOAD)
    else $error("status code out of range");

  a_pad_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[OUT_DATA_BITS-1:131] == '0)
    else $error("padding bits set");

  a_good_step: assert property (@(posedge clk) disable iff (!rst_n)
    out_fire && is_ok |-> good16 == prev_good_r + 16'd1 && err16 == prev_err_r)
    else $error("good frame counters out of step");

  a_rej_step: assert property (@(posedge clk) disable iff (!rst_n)
    out_fire && !is_ok |-> err16 == prev_err_r + 16'd1 && good16 == prev_good_r)
    else $error("rejected frame counters out of step");

endmodule

bind prbs_frame_checker pfc_checker u_pfc_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);
`default_nettype wire

// ===== test/prbs_frame_checker_test.sv =====
// Self-checking testbench for the PRBS frame checker: directed frames, then random frames.
module prbs_frame_checker_test;
  timeunit 1ns;
  timeprecision 1ps;
  import pfc_pkg::*;

  localparam int CLK_PERIOD  = 20;
  localparam int PHASE_ITEMS = 125;
  localparam int LONG_HOLD   = 300;
  localparam int SETTLE      = 8;
  localparam int CYCLE_LIMIT = 200000;
  localparam logic [63:0] NARROW_MASK = 64'h0000_0000_FFFF_FFFF;

  typedef struct packed {
    status_t     status;
    logic [31:0] rejected;
    logic [31:0] good;
    logic [31:0] byte_total;
    logic [31:0] next_seq;
  } frame_report_t;

  typedef struct packed {
    logic [63:0]   data;
    logic          last;
    logic [3:0]    vb;
    logic          ferr;
    logic          hand;
    frame_report_t rep;
  } script_row_t;

  logic                      clk = 1'b0;
  logic                      rst_n = 1'b0;
  logic                      in_tvalid = 1'b0;
  logic                      in_tready;
  logic [DATA_BITS-1:0]      in_tdata = '0;
  logic                      in_tlast = 1'b0;
  logic [IN_USER_BITS-1:0]   in_tuser = '0;
  logic                      out_tvalid;
  logic                      out_tready = 1'b0;
  logic [OUT_DATA_BITS-1:0]  out_tdata;
  logic                      cfg_valid = 1'b0;
  logic                      cfg_ready;
  logic [CFG_INDEX_BITS-1:0] cfg_index = '0;
  logic [DATA_BITS-1:0]      cfg_data = '0;

  // checker model state
  bit          cfg_wide;
  logic [63:0] cfg_taps;
  bit          cfg_check;
  logic [31:0] want_seq;
  logic [63:0] prbs_state;
  logic [31:0] word_idx;
  logic [31:0] hdr_seq;
  logic [31:0] hdr_size;
  bit          payload_miss;
  bit          link_err;
  logic [31:0] rejected_cnt;
  logic [31:0] good_cnt;
  logic [31:0] good_byte_cnt;

  frame_report_t report_q[$];
  script_row_t   script [24];
  int            idle_pct = 0;
  bit            hold_out = 1'b0;
  int            items_sent = 0;
  int            fails = 0;
  int            cycles = 0;

  prbs_frame_checker u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("[prbs_frame_checker] ERROR");
      $finish;
    end
  end

  function automatic logic [63:0] word_mask();
    return cfg_wide ? '1 : NARROW_MASK;
  endfunction

  function automatic logic [63:0] prbs_step(input logic [63:0] v);
    logic [63:0] m;
    m = word_mask();
    return ((v << 1) | 64'(^(v & cfg_taps & m))) & m;
  endfunction

  task automatic model_reset();
    cfg_wide      = 1'b0;
    cfg_taps      = TAP_MASK_RESET;
    cfg_check     = 1'b1;
    want_seq      = '0;
    prbs_state    = '0;
    word_idx      = '0;
    hdr_seq       = '0;
    hdr_size      = '0;
    payload_miss  = 1'b0;
    link_err      = 1'b0;
    rejected_cnt  = '0;
    good_cnt      = '0;
    good_byte_cnt = '0;
  endtask

  task automatic score_word(input logic [63:0] data, input bit last, input logic [3:0] vb,
                            input bit ferr, output bit has_rep, output frame_report_t rep);
    logic [63:0] w;
    logic [3:0]  bpw;
    logic [32:0] words;
    logic [31:0] prev_seq;
    status_t     st;
    w       = data & word_mask();
    bpw     = cfg_wide ? BYTES_WIDE : BYTES_NARROW;
    has_rep = 1'b0;
    rep     = '0;
    if (ferr) link_err = 1'b1;
    if (word_idx == 0) begin
      hdr_seq    = w[31:0];
      prbs_state = w;
    end else if (word_idx == 1) begin
      hdr_size = w[31:0];
    end else if (cfg_check) begin
      prbs_state = prbs_step(prbs_state);
      if (prbs_state != w) payload_miss = 1'b1;
    end
    words = {1'b0, word_idx} + 33'd1;
    if (word_idx != '1) word_idx = word_idx + 1;
    if (last) begin
      if (link_err) begin
        st = ST_FRAME_ERR;
      end else if (vb < bpw || words < MIN_WORDS) begin
        st = ST_SIZE;
      end else begin
        prev_seq = want_seq;
        want_seq = hdr_seq + 1;
        if ({1'b0, hdr_size} + 33'd1 != words ||
            (hdr_seq != 0 && prev_seq != 0 && hdr_seq != prev_seq))
          st = ST_HEADER;
        else if (payload_miss)
          st = ST_PAYLOAD;
        else
          st = ST_OK;
      end
      if (st == ST_OK) begin
        good_cnt      = good_cnt + 1;
        good_byte_cnt = good_byte_cnt + words[31:0] * 32'(bpw);
      end else begin
        rejected_cnt = rejected_cnt + 1;
      end
      word_idx     = '0;
      payload_miss = 1'b0;
      link_err     = 1'b0;
      has_rep      = 1'b1;
      rep          = '{st, rejected_cnt, good_cnt, good_byte_cnt, want_seq};
    end
  endtask

  task automatic send_word(input logic [63:0] data, input bit last, input logic [3:0] vb,
                           input bit ferr, input bit hand, input frame_report_t hand_rep);
    bit            has_rep;
    frame_report_t rep;
    if (idle_pct != 0 && $urandom_range(0, 99) < idle_pct) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= data;
    in_tlast  <= last;
    in_tuser  <= {ferr, vb};
    do @(posedge clk); while (!in_tready);
    score_word(data, last, vb, ferr, has_rep, rep);
    items_sent++;
    if (has_rep) report_q.push_back(hand ? hand_rep : rep);
  endtask

  task automatic write_reg(input logic [CFG_INDEX_BITS-1:0] idx, input logic [63:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      CFG_WIDE_WORDS:    cfg_wide  = value[0];
      CFG_TAP_MASK:      cfg_taps  = value;
      CFG_CHECK_PAYLOAD: cfg_check = value[0];
      default: ;
    endcase
  endtask

  task automatic wait_quiet();
    while (report_q.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic send_frame();
    int          n;
    int          bad_at;
    int          err_at;
    int          roll;
    logic [63:0] m;
    logic [63:0] seed;
    logic [63:0] g;
    logic [63:0] w;
    logic [31:0] seq;
    logic [31:0] size;
    logic [3:0]  vb;
    m    = word_mask();
    roll = $urandom_range(0, 99);
    if (roll < 8) begin
      n = $urandom_range(1, 8);
      for (int i = 0; i < n; i++)
        send_word({$urandom, $urandom}, i == n - 1, 4'($urandom_range(0, 15)),
                  $urandom_range(0, 3) == 0, 1'b0, '0);
    end else begin
      roll = $urandom_range(0, 99);
      if (roll < 6)       n = $urandom_range(1, 2);
      else if (roll < 10) n = $urandom_range(11, 40);
      else                n = $urandom_range(3, 10);
      roll = $urandom_range(0, 99);
      if (roll < 70)      seq = want_seq;
      else if (roll < 80) seq = '0;
      else if (roll < 85) seq = '1;
      else                seq = $urandom;
      size   = ($urandom_range(0, 9) != 0) ? 32'(n - 1) : 32'($urandom);
      bad_at = (n >= 3 && $urandom_range(0, 9) == 0) ? $urandom_range(2, n - 1) : -1;
      err_at = ($urandom_range(0, 19) == 0) ? $urandom_range(0, n - 1) : -1;
      if ($urandom_range(0, 99) < 85)
        vb = cfg_wide ? 4'($urandom_range(8, 15)) : 4'($urandom_range(4, 15));
      else
        vb = 4'($urandom_range(0, 15));
      seed = {$urandom, seq};
      g    = seed & m;
      for (int i = 0; i < n; i++) begin
        if (i == 0) begin
          w = seed;
        end else if (i == 1) begin
          w = {$urandom, size};
        end else begin
          g = prbs_step(g);
          w = g | (~m & {$urandom, $urandom});
        end
        if (i == bad_at) w = w ^ (64'h1 << $urandom_range(0, cfg_wide ? 63 : 31));
        send_word(w, i == n - 1, (i == n - 1) ? vb : 4'($urandom_range(0, 15)),
                  i == err_at, 1'b0, '0);
      end
    end
  endtask

  task automatic run_phase(input bit wide, input logic [63:0] taps, input bit check,
                           input int idle, input bit long_stall);
    int start;
    in_tvalid <= 1'b0;
    wait_quiet();
    write_reg(CFG_WIDE_WORDS, {63'd0, wide});
    write_reg(CFG_TAP_MASK, taps);
    write_reg(CFG_CHECK_PAYLOAD, {63'd0, check});
    cfg_valid <= 1'b0;
    idle_pct = idle;
    if (long_stall) hold_out = 1'b1;
    start = items_sent;
    while (items_sent - start < PHASE_ITEMS) send_frame();
  endtask

  initial begin
    forever begin
      @(posedge clk);
      if (hold_out) begin
        hold_out = 1'b0;
        out_tready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
        out_tready <= 1'b1;
      end else if (idle_pct != 0 && $urandom_range(0, 99) < idle_pct) begin
        out_tready <= 1'b0;
        repeat ($urandom_range(1, 3)) @(posedge clk);
        out_tready <= 1'b1;
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin : result_check
    frame_report_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (report_q.size() == 0) begin
        $error("unexpected result: out_tdata=%h", out_tdata);
        fails++;
      end else begin
        want = report_q.pop_front();
        if (out_tdata[2:0] !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, out_tdata[2:0]);
          fails++;
        end
        if (out_tdata[34:3] !== want.rejected) begin
          $error("error_count: expected %0d, got %0d", want.rejected, out_tdata[34:3]);
          fails++;
        end
        if (out_tdata[66:35] !== want.good) begin
          $error("frame_count: expected %0d, got %0d", want.good, out_tdata[66:35]);
          fails++;
        end
        if (out_tdata[98:67] !== want.byte_total) begin
          $error("byte_count: expected %0d, got %0d", want.byte_total, out_tdata[98:67]);
          fails++;
        end
        if (out_tdata[130:99] !== want.next_seq) begin
          $error("next_sequence: expected %h, got %h", want.next_seq, out_tdata[130:99]);
          fails++;
        end
      end
    end
  end

  initial begin
    script = '{
      '{64'h1,                   1'b0, 4'd0,  1'b0, 1'b0, '0},
      '{64'hFFFF_FFFF_0000_0002, 1'b0, 4'd0,  1'b0, 1'b0, '0},
      '{64'h2,                   1'b1, 4'd4,  1'b0, 1'b1, '{ST_OK, 32'd0, 32'd1, 32'd12, 32'd2}},
      '{64'h2,                   1'b0, 4'd0,  1'b1, 1'b0, '0},
      '{64'h2,                   1'b0, 4'd0,  1'b0, 1'b0, '0},
      '{64'h5,                   1'b1, 4'd4,  1'b0, 1'b1,
        '{ST_FRAME_ERR, 32'd1, 32'd1, 32'd12, 32'd2}},
      '{64'h2,                   1'b0, 4'd0,  1'b0, 1'b0, '0},
      '{64'h1,                   1'b1, 4'd4,  1'b0, 1'b1, '{ST_SIZE, 32'd2, 32'd1, 32'd12, 32'd2}},
      '{64'h2,                   1'b0, 4'd0,  1'b0, 1'b0, '0},
      '{64'h2,                   1'b0, 4'd0,  1'b0, 1'b0, '0},
      '{64'h5,                   1'b1, 4'd0,  1'b0, 1'b1, '{ST_SIZE, 32'd3, 32'd1, 32'd12, 32'd2}},
      '{64'h2,                   1'b0, 4'd0,  1'b0, 1'b0, '0},
      '{64'h5,                   1'b0, 4'd0,  1'b0, 1'b0, '0},
      '{64'h5,                   1'b1, 4'd4,  1'b0, 1'b1,
        '{ST_HEADER, 32'd4, 32'd1, 32'd12, 32'd3}},
      '{64'h7,                   1'b0, 4'd0,  1'b0, 1'b0, '0},
      '{64'h2,                   1'b0, 4'd0,  1'b0, 1'b0, '0},
      '{64'hE,                   1'b1, 4'd4,  1'b0, 1'b1,
        '{ST_HEADER, 32'd5, 32'd1, 32'd12, 32'd8}},
      '{64'h0,                   1'b0, 4'd0,  1'b0, 1'b0, '0},
      '{64'h2,                   1'b0, 4'd0,  1'b0, 1'b0, '0},
      '{64'hFFFF_FFFF_FFFF_FFFF, 1'b1, 4'd15, 1'b0, 1'b1,
        '{ST_PAYLOAD, 32'd6, 32'd1, 32'd12, 32'd1}},
      '{64'h1,                   1'b0, 4'd0,  1'b0, 1'b0, '0},
      '{64'h3,                   1'b0, 4'd0,  1'b0, 1'b0, '0},
      '{64'h2,                   1'b0, 4'd0,  1'b0, 1'b0, '0},
      '{64'h5,                   1'b1, 4'd8,  1'b0, 1'b1, '{ST_OK, 32'd6, 32'd2, 32'd28, 32'd2}}
    };
    model_reset();
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    idle_pct = 20;
    foreach (script[i])
      send_word(script[i].data, script[i].last, script[i].vb, script[i].ferr,
                script[i].hand, script[i].rep);

    run_phase(1'b1, 64'hD800_0000_0000_0000, 1'b1, 20, 1'b0);
    run_phase(1'b1, '1,                      1'b1, 30, 1'b1);
    run_phase(1'b0, '0,                      1'b1, 0,  1'b0);
    run_phase(1'b1, {$urandom, $urandom},    1'b0, 20, 1'b0);
    run_phase(1'b0, TAP_MASK_RESET,          1'b1, 30, 1'b0);
    run_phase(1'b0, '1,                      1'b0, 10, 1'b0);
    run_phase(1'b1, {$urandom, $urandom},    1'b1, 20, 1'b0);
    run_phase(1'b0, {$urandom, $urandom},    1'b1, 0,  1'b0);

    in_tvalid <= 1'b0;
    wait_quiet();
    if (fails == 0) begin
      $display("[prbs_frame_checker] OK");
    end else begin
      $display("[prbs_frame_checker] ERROR");
    end
    $finish;
  end

endmodule
